// ----- rtl/core/rbb3_pkg.sv -----
package rbb3_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int LINE_AW    = $clog2(MAX_WIDTH);
  localparam int PIX_W      = 24;
  localparam int CHAN_W     = 8;
  localparam int NUM_LANES  = 3;
  localparam int WIN_TAPS   = 9;

  localparam int COL_W      = 11;
  localparam int ROW_W      = 12;
  localparam int WIDTH_W    = 12;
  localparam int HEIGHT_W   = 13;
  localparam int CFG_AW     = 1;
  localparam int CFG_DW     = 13;

  // divide by nine as multiply by ceil(2^15 / 9) and shift, exact for sums below 2^15
  localparam int SUM_W       = 12;
  localparam int RECIP_SHIFT = 15;
  localparam int PROD_W      = 23;
  localparam logic [SUM_W-1:0] RECIP = SUM_W'(((1 << RECIP_SHIFT) + 8) / 9);

  localparam logic [CFG_AW-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_AW-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  typedef logic [WIN_TAPS-1:0][CHAN_W-1:0] lane_pix_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } meta_t;

endpackage

// ----- rtl/core/rbb3_line_buf.sv -----
module rbb3_line_buf (
  input  logic                                clk,
  input  logic                                rd_en,
  input  logic [rbb3_pkg::LINE_AW-1:0]        rd_addr,
  output logic [2*rbb3_pkg::PIX_W-1:0]        rd_data,
  input  logic                                wr_en,
  input  logic [rbb3_pkg::LINE_AW-1:0]        wr_addr,
  input  logic [2*rbb3_pkg::PIX_W-1:0]        wr_data
);

  // each entry holds the two rows above: {two rows up, one row up}
  logic [2*rbb3_pkg::PIX_W-1:0] mem [rbb3_pkg::MAX_WIDTH];
  logic [2*rbb3_pkg::PIX_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // a write to the same column in the same cycle is passed straight through
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/rbb3_lane.sv -----
module rbb3_lane (
  input  logic                          clk,
  input  logic                          en_sum,
  input  logic                          en_mul,
  input  rbb3_pkg::lane_pix_t           pix,
  output logic [rbb3_pkg::CHAN_W-1:0]   mean
);

  logic [rbb3_pkg::SUM_W-1:0]  sum_nxt;
  logic [rbb3_pkg::SUM_W-1:0]  sum_r;
  logic [rbb3_pkg::PROD_W-1:0] prod_r;

  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < rbb3_pkg::WIN_TAPS; i++) begin
      sum_nxt = sum_nxt + rbb3_pkg::SUM_W'(pix[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en_sum) begin
      sum_r <= sum_nxt;
    end
    if (en_mul) begin
      prod_r <= rbb3_pkg::PROD_W'(sum_r) * rbb3_pkg::PROD_W'(rbb3_pkg::RECIP);
    end
  end

  assign mean = prod_r[rbb3_pkg::RECIP_SHIFT +: rbb3_pkg::CHAN_W];

endmodule

// ----- rtl/core/rgb_box_blur_3x3.sv -----
// channel  dir  handshake              payload
// in       in   in_tvalid/in_tready    in_tdata: red, green, blue
// out      out  out_tvalid/out_tready  out_tdata: red, green, blue, row, col; out_tlast
// cfg      in   cfg_we                 cfg_addr, cfg_wdata (0 width, 1 height)
//
// one pixel per cycle sustained while the output is not held; the pixel that
// completes a window passes line read, lane sums, multiply and output stages
// the line store is one read and one write of a single memory per pixel
// rst_n is synchronous; the line store needs no clearing pass
// stages advance independently, so bubbles close up behind a stalled output
module rgb_box_blur_3x3 (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [23:0]                   in_tdata,   // red, green, blue
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [47:0]                   out_tdata,  // red, green, blue, out_row, out_col, pad
  output logic                          out_tlast,  // last_pixel
  input  logic                          cfg_we,
  input  logic [rbb3_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [rbb3_pkg::CFG_DW-1:0]   cfg_wdata
);

  localparam int PW = rbb3_pkg::PIX_W;
  localparam int CW = rbb3_pkg::CHAN_W;

  logic [rbb3_pkg::WIDTH_W-1:0]  width_r;
  logic [rbb3_pkg::HEIGHT_W-1:0] height_r;
  logic [rbb3_pkg::WIDTH_W-1:0]  w_eff;
  logic [rbb3_pkg::HEIGHT_W-1:0] h_eff;

  logic [rbb3_pkg::COL_W-1:0] col_r;
  logic [rbb3_pkg::ROW_W-1:0] row_r;
  logic                       col_end;
  logic                       row_end;
  logic                       acc;

  logic [PW-1:0]              px_in;
  logic                       v1_r;
  logic                       emit1_r;
  logic [PW-1:0]              px1_r;
  logic [rbb3_pkg::COL_W-1:0] addr1_r;
  rbb3_pkg::meta_t            meta1_r;
  logic                       v2_r;
  rbb3_pkg::meta_t            meta2_r;
  logic                       v3_r;
  rbb3_pkg::meta_t            meta3_r;

  logic go1, go2, go3, rdy2, rdy3;

  logic [2*PW-1:0] line_rd;
  logic [PW-1:0]   top_px;
  logic [PW-1:0]   mid_px;
  logic [PW-1:0]   win_r [6];

  rbb3_pkg::lane_pix_t    lane_pix  [rbb3_pkg::NUM_LANES];
  logic [CW-1:0]          lane_mean [rbb3_pkg::NUM_LANES];

  logic        out_valid_r;
  logic [47:0] out_tdata_r;
  logic        out_tlast_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= rbb3_pkg::WIDTH_W'(640);
      height_r <= rbb3_pkg::HEIGHT_W'(480);
    end else if (cfg_we) begin
      case (cfg_addr)
        rbb3_pkg::CFG_IMAGE_WIDTH:  width_r  <= cfg_wdata[rbb3_pkg::WIDTH_W-1:0];
        rbb3_pkg::CFG_IMAGE_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    w_eff = width_r;
    if (width_r == '0) begin
      w_eff = rbb3_pkg::WIDTH_W'(1);
    end else if (width_r > rbb3_pkg::WIDTH_W'(rbb3_pkg::MAX_WIDTH)) begin
      w_eff = rbb3_pkg::WIDTH_W'(rbb3_pkg::MAX_WIDTH);
    end
    h_eff = height_r;
    if (height_r == '0) begin
      h_eff = rbb3_pkg::HEIGHT_W'(1);
    end else if (height_r > rbb3_pkg::HEIGHT_W'(rbb3_pkg::MAX_HEIGHT)) begin
      h_eff = rbb3_pkg::HEIGHT_W'(rbb3_pkg::MAX_HEIGHT);
    end
  end

  // stage handshakes, each stage moves when the one after it has room; stage 1 also moves with no window to pass on
  assign go3  = v3_r && (!out_valid_r || out_tready);
  assign rdy3 = !v3_r || go3;
  assign go2  = v2_r && rdy3;
  assign rdy2 = !v2_r || go2;
  assign go1  = v1_r && (!emit1_r || rdy2);
  assign in_tready = !v1_r || go1;
  assign acc = in_tvalid && in_tready;

  assign px_in   = {in_tdata[7:0], in_tdata[15:8], in_tdata[23:16]};
  assign col_end = (rbb3_pkg::WIDTH_W'(col_r) + rbb3_pkg::WIDTH_W'(1)) >= w_eff;
  assign row_end = (rbb3_pkg::HEIGHT_W'(row_r) + rbb3_pkg::HEIGHT_W'(1)) >= h_eff;

  // raster position of the next pixel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (acc) begin
      if (col_end) begin
        col_r <= '0;
        row_r <= row_end ? '0 : row_r + rbb3_pkg::ROW_W'(1);
      end else begin
        col_r <= col_r + rbb3_pkg::COL_W'(1);
      end
    end
  end

  // stage 1: line store read in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (acc) begin
      v1_r <= 1'b1;
    end else if (go1) begin
      v1_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      px1_r        <= px_in;
      addr1_r      <= col_r;
      emit1_r      <= (row_r >= rbb3_pkg::ROW_W'(2)) && (col_r >= rbb3_pkg::COL_W'(2));
      meta1_r.row  <= row_r - rbb3_pkg::ROW_W'(1);
      meta1_r.col  <= col_r - rbb3_pkg::COL_W'(1);
      meta1_r.last <= col_end && row_end;
    end
  end

  rbb3_line_buf u_line_buf (
    .clk     (clk),
    .rd_en   (acc),
    .rd_addr (rbb3_pkg::LINE_AW'(col_r)),
    .rd_data (line_rd),
    .wr_en   (go1),
    .wr_addr (rbb3_pkg::LINE_AW'(addr1_r)),
    .wr_data ({mid_px, px1_r})
  );

  assign top_px = line_rd[2*PW-1:PW];
  assign mid_px = line_rd[PW-1:0];

  // window: entries 0..2 two columns back, 3..5 one column back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else if (go1) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= top_px;
      win_r[4] <= mid_px;
      win_r[5] <= px1_r;
    end
  end

  always_comb begin
    for (int c = 0; c < rbb3_pkg::NUM_LANES; c++) begin
      for (int i = 0; i < 6; i++) begin
        lane_pix[c][i] = win_r[i][(2-c)*CW +: CW];
      end
      lane_pix[c][6] = top_px[(2-c)*CW +: CW];
      lane_pix[c][7] = mid_px[(2-c)*CW +: CW];
      lane_pix[c][8] = px1_r[(2-c)*CW +: CW];
    end
  end

  for (genvar c = 0; c < rbb3_pkg::NUM_LANES; c++) begin : g_lane
    rbb3_lane u_lane (
      .clk    (clk),
      .en_sum (go1 && emit1_r),
      .en_mul (go2),
      .pix    (lane_pix[c]),
      .mean   (lane_mean[c])
    );
  end

  // stages 2 and 3 carry position alongside the lane sums and products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (go1 && emit1_r) begin
        v2_r <= 1'b1;
      end else if (go2) begin
        v2_r <= 1'b0;
      end
      if (go2) begin
        v3_r <= 1'b1;
      end else if (go3) begin
        v3_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go1 && emit1_r) begin
      meta2_r <= meta1_r;
    end
    if (go2) begin
      meta3_r <= meta2_r;
    end
  end

  // merge lane results into the output word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (go3) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go3) begin
      out_tdata_r <= {1'b0, meta3_r.col, meta3_r.row, lane_mean[2], lane_mean[1], lane_mean[0]};
      out_tlast_r <= meta3_r.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  a_out_from_stage3 : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(v3_r))
    else $error("output word loaded without a stage 3 result");

  a_accept_fills_stage1 : assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> v1_r)
    else $error("accepted pixel missing from stage 1");

  a_full_pipe_blocks : assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && emit1_r && v2_r && v3_r && out_valid_r && !out_tready) |-> !in_tready)
    else $error("input taken while every stage is held");

endmodule

// ----- verif/rgb_box_blur_3x3_check.sv -----
module rgb_box_blur_3x3_check (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  input  logic                        in_tready,
  input  logic [23:0]                 in_tdata,   // red, green, blue
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic [47:0]                 out_tdata,  // red, green, blue, out_row, out_col, pad
  input  logic                        out_tlast,  // last_pixel
  input  logic                        cfg_we,
  input  logic [rbb3_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [rbb3_pkg::CFG_DW-1:0] cfg_wdata,
  output int                          errors,
  output int                          outstanding,
  output int                          means_seen
);

  typedef struct packed {
    logic [rbb3_pkg::CHAN_W-1:0] red;
    logic [rbb3_pkg::CHAN_W-1:0] green;
    logic [rbb3_pkg::CHAN_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [rbb3_pkg::CHAN_W-1:0] red;
    logic [rbb3_pkg::CHAN_W-1:0] green;
    logic [rbb3_pkg::CHAN_W-1:0] blue;
    logic [rbb3_pkg::ROW_W-1:0]  row;
    logic [rbb3_pkg::COL_W-1:0]  col;
    logic                        last;
  } mean_t;

  rgb_t                          row_above  [rbb3_pkg::MAX_WIDTH];
  rgb_t                          row_above2 [rbb3_pkg::MAX_WIDTH];
  rgb_t                          win        [6];
  int unsigned                   col_pos;
  int unsigned                   row_pos;
  logic [rbb3_pkg::WIDTH_W-1:0]  width_reg;
  logic [rbb3_pkg::HEIGHT_W-1:0] height_reg;
  mean_t                         mean_q [$];
  mean_t                         due;

  task automatic note_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    end
  endtask

  // one pixel into the window; queues the mean once a full interior window is seen
  task automatic slide_window(input rgb_t px);
    int unsigned w, h, idx, sr, sg, sb, i;
    rgb_t        top, mid;
    mean_t       m;
    logic        col_end, row_end;
    w = (width_reg == 0) ? 1 : ((width_reg > rbb3_pkg::MAX_WIDTH) ?
                                rbb3_pkg::MAX_WIDTH : width_reg);
    h = (height_reg == 0) ? 1 : ((height_reg > rbb3_pkg::MAX_HEIGHT) ?
                                 rbb3_pkg::MAX_HEIGHT : height_reg);
    idx = (col_pos < rbb3_pkg::MAX_WIDTH) ? col_pos : rbb3_pkg::MAX_WIDTH - 1;
    top = row_above2[idx];
    mid = row_above[idx];
    col_end = (col_pos + 1 >= w);
    row_end = (row_pos + 1 >= h);
    if (row_pos >= 2 && col_pos >= 2) begin
      sr = px.red + top.red + mid.red;
      sg = px.green + top.green + mid.green;
      sb = px.blue + top.blue + mid.blue;
      for (i = 0; i < 6; i++) begin
        sr += win[i].red;
        sg += win[i].green;
        sb += win[i].blue;
      end
      m.red   = rbb3_pkg::CHAN_W'(sr / rbb3_pkg::WIN_TAPS);
      m.green = rbb3_pkg::CHAN_W'(sg / rbb3_pkg::WIN_TAPS);
      m.blue  = rbb3_pkg::CHAN_W'(sb / rbb3_pkg::WIN_TAPS);
      m.row   = rbb3_pkg::ROW_W'(row_pos - 1);
      m.col   = rbb3_pkg::COL_W'(col_pos - 1);
      m.last  = col_end && row_end;
      mean_q.push_back(m);
    end
    win[0] = win[3];
    win[1] = win[4];
    win[2] = win[5];
    win[3] = top;
    win[4] = mid;
    win[5] = px;
    row_above2[idx] = mid;
    row_above[idx]  = px;
    if (col_end) begin
      col_pos = 0;
      row_pos = row_end ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      col_pos    = 0;
      row_pos    = 0;
      width_reg  = rbb3_pkg::WIDTH_W'(640);
      height_reg = rbb3_pkg::HEIGHT_W'(480);
      for (int i = 0; i < 6; i++) win[i] = '0;
      outstanding <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (mean_q.size() == 0) begin
          errors++;
          $display("%0t: result word with none expected, tdata %h last %b",
                   $time, out_tdata, out_tlast);
        end else begin
          due = mean_q.pop_front();
          means_seen++;
          note_field("red", due.red, out_tdata[7:0]);
          note_field("green", due.green, out_tdata[15:8]);
          note_field("blue", due.blue, out_tdata[23:16]);
          note_field("row", due.row, out_tdata[35:24]);
          note_field("col", due.col, out_tdata[46:36]);
          note_field("pad", 16'd0, out_tdata[47]);
          note_field("last", due.last, out_tlast);
        end
      end
      if (in_tvalid && in_tready) begin
        slide_window('{red: in_tdata[7:0], green: in_tdata[15:8], blue: in_tdata[23:16]});
      end
      if (cfg_we) begin
        if (cfg_addr == rbb3_pkg::CFG_IMAGE_WIDTH) begin
          width_reg = cfg_wdata[rbb3_pkg::WIDTH_W-1:0];
        end else if (cfg_addr == rbb3_pkg::CFG_IMAGE_HEIGHT) begin
          height_reg = cfg_wdata[rbb3_pkg::HEIGHT_W-1:0];
        end
      end
      outstanding <= mean_q.size();
    end
  end

endmodule

// ----- verif/rgb_box_blur_3x3_test.sv -----
module rgb_box_blur_3x3_test;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_tvalid = 1'b0;
  logic                        in_tready;
  logic [23:0]                 in_tdata = '0;
  logic                        out_tvalid;
  logic                        out_tready = 1'b0;
  logic [47:0]                 out_tdata;
  logic                        out_tlast;
  logic                        cfg_we = 1'b0;
  logic [rbb3_pkg::CFG_AW-1:0] cfg_addr = '0;
  logic [rbb3_pkg::CFG_DW-1:0] cfg_wdata = '0;

  int          errors;
  int          outstanding;
  int          means_seen;
  int unsigned pixels_sent;
  int unsigned sizes_run;
  int unsigned eff_w;
  int unsigned eff_h;
  int unsigned burst_left;
  int          hold_asked;
  int          hold_served;

  rgb_box_blur_3x3 u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  rgb_box_blur_3x3_check u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .errors      (errors),
    .outstanding (outstanding),
    .means_seen  (means_seen)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("** rgb_box_blur_3x3: FAILED **");
    $finish;
  end

  // output side: random stretches of stall patterns, plus long hold-offs on request
  initial begin : sink
    int mode;
    int span;
    span = 0;
    mode = 0;
    forever begin
      @(posedge clk);
      if (hold_asked != hold_served) begin
        hold_served++;
        out_tready <= 1'b0;
        repeat (499) @(posedge clk);
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 3);
          span = $urandom_range(1, 80);
        end
        span--;
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 3) != 0);
          2: out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= ~out_tready;
        endcase
      end
    end
  end

  function automatic int unsigned clamp_size(input int unsigned v, input int unsigned cap);
    if (v == 0) return 1;
    if (v > cap) return cap;
    return v;
  endfunction

  function automatic logic [23:0] rand_pixel(input int style);
    logic [23:0] px;
    px = $urandom;
    // saturated channels only
    if (style == 1) px = {{8{px[16]}}, {8{px[8]}}, {8{px[0]}}};
    return px;
  endfunction

  task automatic push_pixel(input logic [23:0] px);
    int unsigned gap;
    in_tdata  <= px;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    pixels_sent++;
    if (burst_left > 1) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 24);
      gap = $urandom_range(0, 8);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // stop offering, wait for every outstanding mean, then let the pipe settle
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rbb3_pkg::CFG_AW-1:0] idx,
                           input logic [rbb3_pkg::CFG_DW-1:0] val);
    cfg_addr  <= idx;
    cfg_wdata <= val;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [rbb3_pkg::CFG_DW-1:0] wd,
                           input logic [rbb3_pkg::CFG_DW-1:0] hd);
    drain();
    write_reg(rbb3_pkg::CFG_IMAGE_WIDTH, wd);
    write_reg(rbb3_pkg::CFG_IMAGE_HEIGHT, hd);
    eff_w = clamp_size(wd[rbb3_pkg::WIDTH_W-1:0], rbb3_pkg::MAX_WIDTH);
    eff_h = clamp_size(hd[rbb3_pkg::HEIGHT_W-1:0], rbb3_pkg::MAX_HEIGHT);
    sizes_run++;
  endtask

  task automatic send_image(input int style);
    repeat (eff_w * eff_h) push_pixel(rand_pixel(style));
  endtask

  initial begin : stimulus
    int                          k;
    int unsigned                 n_rand;
    logic [rbb3_pkg::CFG_DW-1:0] wd;
    logic [rbb3_pkg::CFG_DW-1:0] hd;
    burst_left = $urandom_range(1, 24);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // smallest image, back to back: saturated, zero, then a mixed window
    configure(13'd3, 13'd3);
    repeat (9) push_pixel(24'hFFFFFF);
    repeat (9) push_pixel(24'h000000);
    for (k = 0; k < 9; k++) begin
      push_pixel({8'(k * 31), (k == 0) ? 8'd9 : 8'd8, (k == 4) ? 8'hFF : 8'h00});
    end

    // degenerate and out-of-range sizes
    configure(13'd1, 13'd4);
    send_image(0);
    configure(13'd0, 13'd5);
    send_image(0);
    configure(13'd7, 13'd0);
    send_image(0);
    configure(13'd2, 13'd6);
    send_image(0);
    configure(13'd4, 13'd2);
    send_image(0);

    // oversize height: a few rows, then the height cut so the next row ends the image
    configure(13'd3, 13'h1FFF);
    repeat (15) push_pixel(rand_pixel(1));
    drain();
    write_reg(rbb3_pkg::CFG_IMAGE_HEIGHT, 13'd6);
    repeat (3) push_pixel(rand_pixel(1));

    // oversize width: part of a row, then the width cut below the current column
    configure(13'h1FFF, 13'd3);
    repeat (20) push_pixel(rand_pixel(0));
    drain();
    write_reg(rbb3_pkg::CFG_IMAGE_WIDTH, 13'd4);
    repeat (9) push_pixel(rand_pixel(0));

    // output held off while the sender keeps going, so the input backs up
    configure(13'd16, 13'd10);
    hold_asked++;
    send_image(0);

    // resize in the middle of an image: shrink width mid-row, then height mid-image
    configure(13'd10, 13'd8);
    repeat (25) push_pixel(rand_pixel(0));
    drain();
    write_reg(rbb3_pkg::CFG_IMAGE_WIDTH, 13'd4);
    repeat (9) push_pixel(rand_pixel(0));
    drain();
    write_reg(rbb3_pkg::CFG_IMAGE_HEIGHT, 13'd4);
    repeat (4) push_pixel(rand_pixel(1));

    n_rand = 0;
    while (n_rand < 800) begin
      k = $urandom_range(0, 9);
      if (k == 0) begin
        wd = $urandom_range(0, 2);
        hd = $urandom_range(0, 7);
      end else if (k == 1) begin
        wd = $urandom_range(0, 9);
        hd = $urandom_range(0, 2);
      end else begin
        wd = $urandom_range(3, 16);
        hd = $urandom_range(3, 10);
      end
      // bit above the width register is dropped by the block
      wd[rbb3_pkg::CFG_DW-1] = $urandom_range(0, 1);
      if (n_rand == 0 || $urandom_range(0, 3) != 0) configure(wd, hd);
      else if ($urandom_range(0, 2) == 0) drain();
      send_image(($urandom_range(0, 3) == 2) ? 1 : 0);
      if (eff_w >= 3 && eff_h >= 3) n_rand += eff_w * eff_h;
    end

    drain();
    $display("run covered %0d pixel words and %0d window means over %0d image sizes",
             pixels_sent, means_seen, sizes_run);
    $display("incl. zero and oversize registers, images cut short by mid-row and "
             , "mid-image resizing, and a long output hold-off");
    if (errors == 0 && outstanding == 0) begin
      $display("** rgb_box_blur_3x3: PASSED **");
    end else begin
      $display("** rgb_box_blur_3x3: FAILED **");
    end
    $finish;
  end

endmodule

// ----- rgb_box_blur_3x3.f -----
rtl/core/rbb3_pkg.sv
rtl/core/rbb3_line_buf.sv
rtl/core/rbb3_lane.sv
rtl/core/rgb_box_blur_3x3.sv
verif/rgb_box_blur_3x3_check.sv
verif/rgb_box_blur_3x3_test.sv
